/* rtl/zpd_pkg.sv */
// ----------------------------------------------------------------------------
// zpd_pkg
// Shared types and fixed constants of the z-score peak detector.
// ----------------------------------------------------------------------------
package zpd_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INFLUENCE     = 2'd2;

    localparam int LEN_REG_W = 7;
    localparam int THR_W     = 8;
    localparam int INF_W     = 9;

    localparam logic [LEN_REG_W-1:0] LEN_RESET = 7'd30;
    localparam logic [THR_W-1:0]     THR_RESET = 8'd48;
    localparam logic [INF_W-1:0]     INF_RESET = 9'd0;

    localparam int MIN_WINDOW = 2;

    // blend weights in 1/256 units
    localparam logic [INF_W-1:0] INF_ONE     = 9'd256;
    localparam int               BLEND_ROUND = 128;
    localparam int               BLEND_SHIFT = 8;

    // threshold has four fraction bits
    localparam int THR_FRAC = 4;

    localparam logic [1:0] SIG_NONE = 2'b00;
    localparam logic [1:0] SIG_UP   = 2'b01;
    localparam logic [1:0] SIG_DOWN = 2'b11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMP,
        ST_FILT,
        ST_SQR,
        ST_SUM,
        ST_PROD,
        ST_ROOT,
        ST_MEAN_WAIT,
        ST_DEV_WAIT,
        ST_OUT
    } zpd_state_t;

endpackage

/* rtl/zscore_peak_detector.sv */
// ----------------------------------------------------------------------------
// zscore_peak_detector
// Smoothed z-score peak detector over a sliding window of filtered samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream carries one sample per transaction (tdata = sample, tlast =
//   end of series). m_* stream returns one result per sample: tdata =
//   signal, filtered, window_mean, window_deviation; tuser = stats_valid;
//   tlast = copy of the input tlast.
//   cfg_* writes window_length (0), threshold_q4 (1), influence_q8 (2).
//   Writing window_length empties the window. Write config only when idle.
// Sequencing:
//   One sample at a time; s_tready is high only while idle. With the window
//   full the time per sample is set by the square root (one bit per cycle),
//   run alongside the divide of the sum for the mean, and then the divide
//   of the root by the window length (one quotient bit per cycle). During
//   warm-up neither the root nor the divides are run.
// Reset:
//   Window empty, sums and previous statistics zero, registers at 30/48/0.
//   The sample store itself is not cleared; entries are read only after
//   being written since the last restart.
// Stall:
//   The result sits in the output register until m_tready. The next sample
//   is already accepted and processed; it waits at the end if the output
//   register is still full.
// ----------------------------------------------------------------------------
module zscore_peak_detector
    import zpd_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    // input stream; tdata: sample
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]            s_tdata,
    input  logic                                        s_tlast,
    // result stream; tdata: signal, filtered, window_mean, window_deviation
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [((2+3*SAMPLE_BITS+7)/8)*8-1:0]        m_tdata,
    // tuser: stats_valid
    output logic                                        m_tuser,
    output logic                                        m_tlast,
    // configuration writes
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]                        cfg_index,
    input  logic [CFG_DATA_W-1:0]                       cfg_data
);

    localparam int S       = SAMPLE_BITS;
    localparam int AW      = $clog2(MAX_WINDOW + 1);   // holds a length
    localparam int PW      = $clog2(MAX_WINDOW);       // store address
    localparam int SUM_W   = S + AW;
    localparam int SQ_W    = 2 * S + AW;
    localparam int NUM_W   = 2 * S + 2 * AW + 1;
    localparam int RAD_W   = NUM_W - 1;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int DIV_W   = SUM_W;
    localparam int ACC_W   = S + 11;
    localparam int MAG_W   = S + 1 + THR_FRAC;
    localparam int LIM_W   = S + THR_W;
    localparam int OUT_W   = ((2 + 3 * S + 7) / 8) * 8;

    // ---------------- configuration registers ----------------
    logic [LEN_REG_W-1:0] len_cfg_reg;
    logic [THR_W-1:0]     thr_reg;
    logic [INF_W-1:0]     inf_reg;
    logic                 cfg_fire;
    logic                 restart;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign restart   = cfg_fire && (cfg_index == REG_WINDOW_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= LEN_RESET;
            thr_reg     <= THR_RESET;
            inf_reg     <= INF_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_WINDOW_LENGTH: len_cfg_reg <= cfg_data[LEN_REG_W-1:0];
                REG_THRESHOLD:     thr_reg     <= cfg_data[THR_W-1:0];
                REG_INFLUENCE:     inf_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // clamped window length
    logic [AW-1:0] len_eff;
    always_comb
    begin
        int l;
        l = int'(len_cfg_reg);
        if (l < MIN_WINDOW)
        begin
            l = MIN_WINDOW;
        end
        if (l > MAX_WINDOW)
        begin
            l = MAX_WINDOW;
        end
        len_eff = AW'(l);
    end

    // ---------------- control ----------------
    zpd_state_t state_reg, state_next;

    logic s_fire;
    logic out_free;
    logic div_busy, sqrt_busy;
    logic div_start, sqrt_start;
    logic mem_re, mem_we;

    logic [PW-1:0] wp_reg;
    logic [PW-1:0] wp_eff;
    logic [AW-1:0] fill_reg;
    logic          valid_reg;

    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;
    assign wp_eff   = (AW'(wp_reg) >= len_eff) ? '0 : wp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                mem_re   = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:  state_next = ST_FILT;
            ST_FILT:
            begin
                mem_we     = 1'b1;
                state_next = ST_SQR;
            end
            ST_SQR:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_PROD;
            ST_PROD:
            begin
                if (valid_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_ROOT;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_ROOT:
            begin
                sqrt_start = 1'b1;
                state_next = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (!div_busy && !sqrt_busy)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DEV_WAIT;
                end
            end
            ST_DEV_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- datapath ----------------
    logic signed [S-1:0]     x_reg;
    logic                    last_reg;
    logic [AW-1:0]           len_reg;
    logic                    full_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic [LIM_W-1:0]        lim_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [S-1:0]     filt_reg;
    logic signed [S-1:0]     old_reg;
    logic [1:0]              sig_reg;
    logic [SQ_W-1:0]         fsq_reg, osq_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [NUM_W-1:0]        prod_a_reg;
    logic signed [NUM_W-1:0] prod_b_reg;
    logic signed [S-1:0]     prev_filt_reg;
    logic signed [S-1:0]     prev_mean_reg;
    logic [S-1:0]            prev_dev_reg;
    logic signed [S-1:0]     mean_reg;
    logic [S-1:0]            dev_reg;

    logic [S-1:0]            mem_rdata;

    // compare and blend terms
    logic signed [S:0]       diff;
    logic [S:0]              abs_diff;
    logic [INF_W-1:0]        inf_eff;
    logic [INF_W-1:0]        inf_rest;
    logic signed [ACC_W-1:0] acc_a, acc_b;
    logic                    flag;
    logic signed [S-1:0]     filt_next;

    always_comb
    begin
        diff     = (S+1)'(x_reg) - (S+1)'(prev_mean_reg);
        abs_diff = diff[S] ? unsigned'(-diff) : unsigned'(diff);
        inf_eff  = (inf_reg > INF_ONE) ? INF_ONE : inf_reg;
        inf_rest = INF_ONE - inf_eff;
        acc_a    = ACC_W'($signed({1'b0, inf_eff})) * ACC_W'(x_reg);
        acc_b    = ACC_W'($signed({1'b0, inf_rest})) * ACC_W'(prev_filt_reg);
        flag     = full_reg && (LIM_W'(mag_reg) > lim_reg);
        filt_next = flag ? acc_reg[BLEND_SHIFT+S-1:BLEND_SHIFT] : x_reg;
    end

    // squares
    logic signed [2*S-1:0] fsq_s, osq_s;
    always_comb
    begin
        fsq_s = (2*S)'(filt_reg) * (2*S)'(filt_reg);
        osq_s = (2*S)'(old_reg) * (2*S)'(old_reg);
    end

    // window statistics
    logic [AW-1:0]           fill_after;
    logic signed [NUM_W-1:0] num;
    logic [RAD_W-1:0]        radicand;
    logic [DIV_W-1:0]        sum_abs;
    logic [DIV_W-1:0]        div_dividend;
    logic [DIV_W-1:0]        div_quo;
    logic [AW-1:0]           div_rem;
    logic [ROOT_W-1:0]       root;
    logic [DIV_W-1:0]        mean_mag;
    logic [DIV_W-1:0]        mean_full;
    logic [PW:0]             wp_inc;

    always_comb
    begin
        fill_after   = full_reg ? fill_reg : fill_reg + 1'b1;
        num          = $signed(prod_a_reg) - prod_b_reg;
        radicand     = (num > 0) ? num[RAD_W-1:0] : '0;
        sum_abs      = sum_reg[SUM_W-1] ? unsigned'(-sum_reg) : unsigned'(sum_reg);
        div_dividend = (state_reg == ST_PROD) ? sum_abs : DIV_W'(root);
        mean_mag     = div_quo + DIV_W'(div_rem != '0);
        mean_full    = sum_reg[SUM_W-1] ? (~mean_mag + 1'b1) : div_quo;
        wp_inc       = {1'b0, wp_reg} + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    x_reg    <= s_tdata[S-1:0];
                    last_reg <= s_tlast;
                    len_reg  <= len_eff;
                    full_reg <= (fill_reg >= len_eff);
                end
            end
            ST_CMP:
            begin
                mag_reg <= {abs_diff, {THR_FRAC{1'b0}}};
                lim_reg <= LIM_W'(thr_reg) * LIM_W'(prev_dev_reg);
                acc_reg <= acc_a + acc_b + ACC_W'(BLEND_ROUND);
            end
            ST_FILT:
            begin
                filt_reg <= filt_next;
                old_reg  <= full_reg ? mem_rdata : '0;
                sig_reg  <= !flag ? SIG_NONE :
                            (x_reg > prev_mean_reg) ? SIG_UP : SIG_DOWN;
            end
            ST_SQR:
            begin
                fsq_reg <= {{AW{1'b0}}, fsq_s};
                osq_reg <= {{AW{1'b0}}, osq_s};
            end
            ST_SUM:
            begin
                valid_reg <= (fill_after >= len_reg);
            end
            ST_PROD:
            begin
                prod_a_reg <= NUM_W'(len_reg) * NUM_W'(sq_reg);
                prod_b_reg <= NUM_W'(sum_reg) * NUM_W'(sum_reg);
                mean_reg   <= '0;
                dev_reg    <= '0;
            end
            ST_MEAN_WAIT:
            begin
                if (!div_busy && !sqrt_busy)
                begin
                    mean_reg <= mean_full[S-1:0];
                end
            end
            ST_DEV_WAIT:
            begin
                if (!div_busy)
                begin
                    dev_reg <= div_quo[S-1:0];
                end
            end
            default: ;
        endcase
    end

    // window state; cleared on reset and, but for the previous filtered sample, on a window length write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            prev_filt_reg <= '0;
            prev_mean_reg <= '0;
            prev_dev_reg  <= '0;
        end
        else if (restart)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            prev_mean_reg <= '0;
            prev_dev_reg  <= '0;
        end
        else
        begin
            if (s_fire)
            begin
                wp_reg <= wp_eff;
            end
            if (state_reg == ST_SUM)
            begin
                sum_reg       <= sum_reg + SUM_W'(filt_reg) - SUM_W'(old_reg);
                sq_reg        <= sq_reg + fsq_reg - osq_reg;
                fill_reg      <= fill_after;
                wp_reg        <= (AW'(wp_inc) >= len_reg) ? '0 : wp_inc[PW-1:0];
                prev_filt_reg <= filt_reg;
            end
            if ((state_reg == ST_OUT) && out_free)
            begin
                prev_mean_reg <= mean_reg;
                prev_dev_reg  <= dev_reg;
            end
        end
    end

    // ---------------- units ----------------
    zpd_window_mem #(
        .DEPTH  (MAX_WINDOW),
        .ADDR_W (PW),
        .DATA_W (S)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wp_reg),
        .wdata (filt_next),
        .re    (mem_re),
        .raddr (wp_eff),
        .rdata (mem_rdata)
    );

    zpd_divider #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (AW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (len_reg),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    zpd_isqrt #(
        .RAD_W (RAD_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .busy     (sqrt_busy),
        .root     (root)
    );

    // ---------------- output register ----------------
    logic              m_valid_reg;
    logic [1:0]        o_sig_reg;
    logic [S-1:0]      o_filt_reg;
    logic [S-1:0]      o_mean_reg;
    logic [S-1:0]      o_dev_reg;
    logic              o_stats_reg;
    logic              o_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_OUT) && out_free)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_OUT) && out_free)
        begin
            o_sig_reg   <= sig_reg;
            o_filt_reg  <= filt_reg;
            o_mean_reg  <= mean_reg;
            o_dev_reg   <= dev_reg;
            o_stats_reg <= valid_reg;
            o_last_reg  <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({o_dev_reg, o_mean_reg, o_filt_reg, o_sig_reg});
    assign m_tuser  = o_stats_reg;
    assign m_tlast  = o_last_reg;

endmodule

/* rtl/zpd_window_mem.sv */
// ----------------------------------------------------------------------------
// zpd_window_mem
// Window sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module zpd_window_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/zpd_divider.sv */
// ----------------------------------------------------------------------------
// zpd_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module zpd_divider #(
    parameter int DIVIDEND_W = 23,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divs_reg;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, divs_reg};
        fits  = (trial >= {1'b0, divs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            divs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/zpd_isqrt.sv */
// ----------------------------------------------------------------------------
// zpd_isqrt
// Floor square root, digit by digit, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module zpd_isqrt #(
    parameter int RAD_W = 46
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [RAD_W-1:0]   radicand,
    output logic               busy,
    output logic [RAD_W/2-1:0] root
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              fits;

    always_comb
    begin
        rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1:RAD_W-2]};
        trial  = {root_reg, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(ROOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

/* sim/tb_zscore_peak_detector.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zscore_peak_detector
// Self-checking bench for the z-score peak detector: a queue-fed sample
// driver, a result monitor and an untimed per-sample predictor of the window
// statistics, run through several register settings with random stalls.
// ----------------------------------------------------------------------------
module tb_zscore_peak_detector;
    import zpd_pkg::*;

    localparam int  WIN_MAX    = 64;
    localparam int  SETTLE     = 80;        // extra wait once the queues are empty
    localparam int  CYCLE_CAP  = 600000;

    typedef struct {
        logic [15:0] sample;
        logic        last;
    } sample_t;

    typedef struct {
        logic [1:0]  sig;
        logic [15:0] filt;
        logic [15:0] mean;
        logic [15:0] dev;
        logic        valid;
        logic        last;
    } peak_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;             // sample
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [55:0] m_tdata;                  // signal, filtered, mean, deviation
    logic m_tuser;                         // stats_valid
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    sample_t      pending_samples[$];
    peak_result_t expected_results[$];
    int           mismatches = 0;
    int           cycles = 0;
    logic         sample_fire = 1'b0;
    logic         calm = 1'b0;             // no idling on either side

    // predictor state
    longint win_store[WIN_MAX];
    int     wptr, fill;
    longint run_sum, run_sq, prev_filt, prev_mean, prev_dev;
    int     len_reg, thr_reg, inf_reg;

    zscore_peak_detector dut (.*);

    always #6 clk = ~clk;

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (v >= res + bit_w)
            begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end
            else
                res = res >> 1;
            bit_w = bit_w >> 2;
        end
        return longint'(res);
    endfunction

    task automatic clear_window();
        wptr = 0; fill = 0; run_sum = 0; run_sq = 0; prev_mean = 0; prev_dev = 0;
    endtask

    task automatic predict_peak(input logic [15:0] raw, input logic last);
        int           len;
        longint       x, filt, mag, inf, num, mean, dev, old;
        peak_result_t r;
        len = (len_reg < 2) ? 2 : (len_reg > WIN_MAX) ? WIN_MAX : len_reg;
        x = longint'($signed(raw));
        filt = x;
        r.sig = SIG_NONE;
        mean = 0;
        dev = 0;
        if (fill >= len)
        begin
            mag = ((x - prev_mean) < 0 ? prev_mean - x : x - prev_mean) * 16;
            if (mag > longint'(thr_reg) * prev_dev)
            begin
                inf = (inf_reg > 256) ? 256 : inf_reg;
                r.sig = (x > prev_mean) ? SIG_UP : SIG_DOWN;
                filt = floor_div(inf * x + (256 - inf) * prev_filt + 128, 256);
            end
        end
        if (wptr >= len)
            wptr = 0;
        if (fill >= len)
        begin
            old = win_store[wptr];
            run_sum -= old;
            run_sq -= old * old;
        end
        else
            fill++;
        win_store[wptr] = filt;
        run_sum += filt;
        run_sq += filt * filt;
        wptr = (wptr + 1 >= len) ? 0 : wptr + 1;
        prev_filt = filt;
        r.valid = (fill >= len);
        if (r.valid)
        begin
            num = len * run_sq - run_sum * run_sum;
            mean = floor_div(run_sum, len);
            if (num > 0)
                dev = int_sqrt(longint'(num / (len * len)));
        end
        prev_mean = mean;
        prev_dev = dev;
        r.filt = filt[15:0];
        r.mean = mean[15:0];
        r.dev = dev[15:0];
        r.last = last;
        expected_results.push_back(r);
    endtask

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        mismatches++;
        $display("ERROR @%0t %s: got %h expected %h", $realtime, what, got, want);
    endtask

    // input side and config tracking at the rising edge
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        sample_fire <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
            predict_peak(s_tdata, s_tlast);
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WINDOW_LENGTH:
                begin
                    len_reg = int'(cfg_data[LEN_REG_W-1:0]);
                    clear_window();
                end
                REG_THRESHOLD: thr_reg = int'(cfg_data[THR_W-1:0]);
                REG_INFLUENCE: inf_reg = int'(cfg_data[INF_W-1:0]);
                default: ;
            endcase
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        peak_result_t w;
        if (m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                report("unexpected result", m_tdata[17:2], 16'h0000);
            end
            else
            begin
                w = expected_results.pop_front();
                if (m_tdata[1:0] !== w.sig)    report("signal", 16'(m_tdata[1:0]), 16'(w.sig));
                if (m_tdata[17:2] !== w.filt)  report("filtered", m_tdata[17:2], w.filt);
                if (m_tdata[33:18] !== w.mean) report("mean", m_tdata[33:18], w.mean);
                if (m_tdata[49:34] !== w.dev)  report("deviation", m_tdata[49:34], w.dev);
                if (m_tuser !== w.valid)       report("stats_valid", 16'(m_tuser), 16'(w.valid));
                if (m_tlast !== w.last)        report("last", 16'(m_tlast), 16'(w.last));
            end
        end
    end

    // sample driver and result back-pressure, falling edge
    always @(negedge clk)
    begin
        sample_t it;
        if (rst_n)
        begin
            if (!s_tvalid || sample_fire)
            begin
                if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= 28))
                begin
                    it = pending_samples.pop_front();
                    s_tdata <= it.sample;
                    s_tlast <= it.last;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= calm || ($urandom_range(99) >= 28);
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_CAP)
        begin
            $display("zscore_peak_detector: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic push(input logic [15:0] v, input logic last);
        sample_t it;
        it.sample = v;
        it.last = last;
        pending_samples.push_back(it);
    endtask

    // mostly a noisy baseline with spikes, some full-range samples
    function automatic logic [15:0] random_sample(input int base);
        int k;
        k = $urandom_range(99);
        if (k < 10)
            return 16'($urandom);
        else if (k < 22)
            return 16'(base + ($urandom_range(1) ? 1 : -1) * $urandom_range(20000, 3000));
        else
            return 16'(base + $urandom_range(400) - 200);
    endfunction

    task automatic run_phase(input int len, input int thr, input int inf, input int n,
                             input bit pause_midway);
        int base;
        write_reg(REG_WINDOW_LENGTH, len);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_INFLUENCE, inf);
        base = $urandom_range(20000) - 10000;
        for (int i = 0; i < n; i++)
        begin
            push(random_sample(base), $urandom_range(15) == 0);
            if (pause_midway && i == n / 2)
                while (pending_samples.size() != 0 || s_tvalid || expected_results.size() != 0)
                    @(posedge clk);
        end
        drain();
    endtask

    initial
    begin
        len_reg = int'(LEN_RESET);
        thr_reg = int'(THR_RESET);
        inf_reg = int'(INF_RESET);
        prev_filt = 0;
        clear_window();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes at reset settings, then a short window for flags
        push(16'h8000, 1'b0); push(16'h7FFF, 1'b1); push(16'h0000, 1'b0);
        push(16'hFFFF, 1'b1); push(16'h5555, 1'b0); push(16'hAAAA, 1'b0);
        drain();
        write_reg(REG_WINDOW_LENGTH, 2);
        write_reg(REG_THRESHOLD, 0);
        write_reg(REG_INFLUENCE, 128);
        push(16'd10, 1'b0); push(16'd12, 1'b0); push(16'h7FFF, 1'b0);
        push(16'h8000, 1'b0); push(16'd0, 1'b0); push(16'd0, 1'b0);
        push(16'd0, 1'b0); push(16'd1, 1'b0); push(16'hFFFF, 1'b1);
        push(16'h7FFF, 1'b0); push(16'h7FFF, 1'b0); push(16'h7FFF, 1'b0);
        push(16'h8000, 1'b0); push(16'h8000, 1'b0); push(16'h8000, 1'b1);
        drain();

        run_phase(2, 0, 256, 60, 1'b0);
        run_phase(64, 255, 511, 150, 1'b1);
        run_phase(0, 16, 64, 60, 1'b0);
        run_phase(1, 48, 300, 50, 1'b0);
        calm = 1'b1;
        run_phase(127, 30, 0, 150, 1'b0);
        calm = 1'b0;
        run_phase(65, 40, 200, 140, 1'b0);
        run_phase(8, 20, 256, 120, 1'b0);
        run_phase(30, 48, 100, 120, 1'b0);
        run_phase(5, 255, 257, 80, 1'b0);

        if (mismatches == 0)
            $display("zscore_peak_detector: match");
        else
            $display("zscore_peak_detector: mismatch");
        $finish;
    end

endmodule

/* sim.f */
rtl/zpd_pkg.sv
rtl/zpd_window_mem.sv
rtl/zpd_divider.sv
rtl/zpd_isqrt.sv
rtl/zscore_peak_detector.sv
sim/tb_zscore_peak_detector.sv
